// ===== rtl/core/quote_aware_comment_stripper_unit_assert.svh =====
// Assertion macros for the comment stripper unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef QUOTE_AWARE_COMMENT_STRIPPER_UNIT_ASSERT_SVH
`define QUOTE_AWARE_COMMENT_STRIPPER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define QACS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define QACS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qacs_pkg.sv =====
// Shared types and constants of the comment stripper unit.
// No dependencies; used by qacs_decide and the top level.
package qacs_pkg;

  localparam int unsigned MAX_DELIM_DEF   = 4;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned PAT_W           = 32;
  localparam int unsigned PAT_BYTES       = PAT_W / BYTE_W;
  localparam int unsigned LEN_W           = 3;
  localparam int unsigned SKIP_W          = 3;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  localparam logic [PAT_W-1:0] OPEN_PATTERN_RST = 32'h0000_2F2F;
  localparam logic [LEN_W-1:0] OPEN_LENGTH_RST  = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_PATTERN  = 2'd0,
    REG_OPEN_LENGTH   = 2'd1,
    REG_CLOSE_PATTERN = 2'd2,
    REG_CLOSE_LENGTH  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PAT_W-1:0] open_pattern;
    logic [LEN_W-1:0] open_length;
    logic [PAT_W-1:0] close_pattern;
    logic [LEN_W-1:0] close_length;
  } cfg_t;

  typedef struct packed {
    logic              quotes;
    logic              comment;
    logic [SKIP_W-1:0] skip;
  } flags_t;

endpackage

// ===== rtl/core/qacs_decide.sv =====
// Keep/drop decision for the byte at the head of the lookahead window.
// Depends on qacs_pkg; purely combinational.
module qacs_decide import qacs_pkg::*; #(
  parameter int unsigned MAX_DELIM = MAX_DELIM_DEF
) (
  input  logic [MAX_DELIM-1:0][BYTE_W-1:0]  window_i,
  input  logic [$clog2(MAX_DELIM+1)-1:0]    fill_i,
  input  flags_t                            flags_i,
  input  cfg_t                              cfg_i,
  output logic                              keep_o,
  output flags_t                            flags_o
);

  localparam int unsigned FILL_W = $clog2(MAX_DELIM + 1);

  function automatic logic [FILL_W-1:0] clamp_len(logic [LEN_W-1:0] len);
    if (int'(len) > int'(MAX_DELIM)) begin
      return FILL_W'(MAX_DELIM);
    end
    return FILL_W'(len);
  endfunction

  logic [FILL_W-1:0]    olen, clen;
  logic [MAX_DELIM-1:0] open_ok, close_ok;
  logic                 open_match, close_match;
  logic [BYTE_W-1:0]    head, next_byte;
  logic                 line_end;

  assign olen = clamp_len(cfg_i.open_length);
  assign clen = clamp_len(cfg_i.close_length);
  assign head = window_i[0];

  for (genvar k = 0; k < MAX_DELIM; k++) begin : g_cmp
    logic [BYTE_W-1:0] open_b, close_b;
    if (k < PAT_BYTES) begin : g_pat
      assign open_b  = cfg_i.open_pattern[BYTE_W*k +: BYTE_W];
      assign close_b = cfg_i.close_pattern[BYTE_W*k +: BYTE_W];
    end else begin : g_zero
      assign open_b  = '0;
      assign close_b = '0;
    end
    // a delimiter byte beyond the held bytes never matches
    assign open_ok[k]  = (olen <= FILL_W'(k)) ||
                         ((FILL_W'(k) < fill_i) && (window_i[k] == open_b));
    assign close_ok[k] = (clen <= FILL_W'(k)) ||
                         ((FILL_W'(k) < fill_i) && (window_i[k] == close_b));
  end

  assign open_match  = &open_ok;
  assign close_match = &close_ok;

  if (MAX_DELIM > 1) begin : g_next
    assign next_byte = window_i[1];
  end else begin : g_no_next
    assign next_byte = '0;
  end

  // a lone CR stays in the comment; CR LF or LF ends it
  assign line_end = (head == CH_LF) ||
                    ((head == CH_CR) && (fill_i > FILL_W'(1)) && (next_byte == CH_LF));

  always_comb begin
    logic pass;
    pass    = 1'b0;
    flags_o = flags_i;
    keep_o  = 1'b0;
    if (flags_i.skip != '0) begin
      flags_o.skip = flags_i.skip - SKIP_W'(1);
    end else begin
      pass = 1'b1;
      if (flags_i.comment) begin
        if (clen == '0) begin
          if (line_end) begin
            flags_o.comment = 1'b0;
          end else begin
            pass = 1'b0;
          end
        end else begin
          if (close_match) begin
            flags_o.skip    = SKIP_W'(clen - FILL_W'(1));
            flags_o.comment = 1'b0;
          end
          pass = 1'b0;
        end
      end
      if (pass) begin
        if (head == CH_QUOTE) begin
          flags_o.quotes = !flags_i.quotes;
        end
        if (!flags_o.quotes && (olen != '0) && open_match) begin
          flags_o.skip    = SKIP_W'(olen - FILL_W'(1));
          flags_o.comment = 1'b1;
        end else begin
          keep_o = 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/quote_aware_comment_stripper_unit.sv =====
// Top level of the comment stripper: input register, window state, result register.
// Depends on qacs_pkg, qacs_decide and quote_aware_comment_stripper_unit_assert.svh.
`include "quote_aware_comment_stripper_unit_assert.svh"

// Strips comments from a byte stream, one byte per transfer, honoring double
// quotes. Bytes are held in a MAX_DELIM-byte lookahead window; once it is full,
// each new byte decides the oldest one, so a text body streams at one byte per
// cycle while the output does not stall, with at most one result per byte. A
// byte marked final empties the window: the core takes it in, decides each
// buffered byte in turn, then sends the last result with end_of_text set (an
// end-only marker with byte_present low if nothing was kept); the input stalls
// until the last result is sent. Each byte passes the input register before its
// result is written to the output register. Configuration writes are always
// ready and take effect at once; write them only while the unit is idle.
module quote_aware_comment_stripper_unit import qacs_pkg::*; #(
  parameter int unsigned MAX_DELIM   = MAX_DELIM_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [PAT_W-1:0]       cfg_data_i,
  // text input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [BYTE_W-1:0]      text_byte_i,
  input  logic                   final_byte_i,
  // results
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BYTE_W-1:0]      kept_byte_o,
  output logic                   byte_present_o,
  output logic                   end_of_text_o,
  output logic [COUNT_WIDTH-1:0] kept_total_o
);

  localparam int unsigned FILL_W = $clog2(MAX_DELIM + 1);

  cfg_t cfg_q;

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_final_q;
  logic              in_take;

  logic [MAX_DELIM-1:0][BYTE_W-1:0] win_q, win_d, win_a;
  logic [FILL_W-1:0]                fill_q, fill_d, fill_a;
  flags_t                           flags_q, flags_d, dec_flags;
  logic [COUNT_WIDTH-1:0]           count_q, count_d, count_inc;
  logic                             flush_q, flush_d;

  logic                   hold_valid_q, hold_valid_d;
  logic [BYTE_W-1:0]      hold_byte_q, hold_byte_d;
  logic [COUNT_WIDTH-1:0] hold_total_q, hold_total_d;

  logic                   out_valid_q, out_valid_d, out_wr;
  logic [BYTE_W-1:0]      out_byte_q, out_byte_d;
  logic                   out_present_q, out_present_d;
  logic                   out_eot_q, out_eot_d;
  logic [COUNT_WIDTH-1:0] out_total_q, out_total_d;

  logic out_free, step_in, step_flush, step_drain, do_head, keep;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_pattern  <= OPEN_PATTERN_RST;
      cfg_q.open_length   <= OPEN_LENGTH_RST;
      cfg_q.close_pattern <= '0;
      cfg_q.close_length  <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_OPEN_PATTERN:  cfg_q.open_pattern  <= cfg_data_i;
        REG_OPEN_LENGTH:   cfg_q.open_length   <= cfg_data_i[LEN_W-1:0];
        REG_CLOSE_PATTERN: cfg_q.close_pattern <= cfg_data_i;
        REG_CLOSE_LENGTH:  cfg_q.close_length  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // step selection
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_in    = in_valid_q && !flush_q && out_free;
  assign step_flush = flush_q && (fill_q != '0) && out_free;
  assign step_drain = flush_q && (fill_q == '0) && out_free;

  assign in_stall_o = in_valid_q && !step_in;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !step_in);

  // append the registered byte to the window
  always_comb begin
    win_a  = win_q;
    fill_a = fill_q;
    if (step_in) begin
      for (int k = 0; k < MAX_DELIM; k++) begin
        if (fill_q == FILL_W'(k)) begin
          win_a[k] = in_byte_q;
        end
      end
      fill_a = fill_q + FILL_W'(1);
    end
  end

  assign do_head = (step_in && !in_final_q && (fill_a == FILL_W'(MAX_DELIM))) || step_flush;

  qacs_decide #(
    .MAX_DELIM (MAX_DELIM)
  ) u_decide (
    .window_i (win_a),
    .fill_i   (fill_a),
    .flags_i  (flags_q),
    .cfg_i    (cfg_q),
    .keep_o   (keep),
    .flags_o  (dec_flags)
  );

  assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);

  always_comb begin
    win_d         = win_a;
    fill_d        = fill_a;
    flags_d       = flags_q;
    count_d       = count_q;
    flush_d       = flush_q;
    hold_valid_d  = hold_valid_q;
    hold_byte_d   = hold_byte_q;
    hold_total_d  = hold_total_q;
    out_wr        = 1'b0;
    out_byte_d    = out_byte_q;
    out_present_d = out_present_q;
    out_eot_d     = out_eot_q;
    out_total_d   = out_total_q;

    if (do_head) begin
      flags_d = dec_flags;
      for (int k = 0; k < MAX_DELIM - 1; k++) begin
        win_d[k] = win_a[k+1];
      end
      win_d[MAX_DELIM-1] = '0;
      fill_d = fill_a - FILL_W'(1);
      if (keep) begin
        count_d = count_inc;
      end
    end

    if (step_in && in_final_q) begin
      flush_d = 1'b1;
    end

    if (step_in && do_head && keep) begin
      out_wr        = 1'b1;
      out_byte_d    = win_a[0];
      out_present_d = 1'b1;
      out_eot_d     = 1'b0;
      out_total_d   = count_inc;
    end

    // while flushing, hold back one kept byte so the last one can carry end_of_text
    if (step_flush && keep) begin
      if (hold_valid_q) begin
        out_wr        = 1'b1;
        out_byte_d    = hold_byte_q;
        out_present_d = 1'b1;
        out_eot_d     = 1'b0;
        out_total_d   = hold_total_q;
      end
      hold_valid_d = 1'b1;
      hold_byte_d  = win_a[0];
      hold_total_d = count_inc;
    end

    if (step_drain) begin
      out_wr    = 1'b1;
      out_eot_d = 1'b1;
      if (hold_valid_q) begin
        out_byte_d    = hold_byte_q;
        out_present_d = 1'b1;
        out_total_d   = hold_total_q;
      end else begin
        out_byte_d    = '0;
        out_present_d = 1'b0;
        out_total_d   = count_q;
      end
      win_d        = '0;
      fill_d       = '0;
      flags_d      = '0;
      count_d      = '0;
      flush_d      = 1'b0;
      hold_valid_d = 1'b0;
    end
  end

  assign out_valid_d = out_wr || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      win_q        <= '0;
      fill_q       <= '0;
      flags_q      <= '0;
      count_q      <= '0;
      flush_q      <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      win_q        <= win_d;
      fill_q       <= fill_d;
      flags_q      <= flags_d;
      count_q      <= count_d;
      flush_q      <= flush_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= text_byte_i;
      in_final_q <= final_byte_i;
    end
    hold_byte_q  <= hold_byte_d;
    hold_total_q <= hold_total_d;
    if (out_wr) begin
      out_byte_q    <= out_byte_d;
      out_present_q <= out_present_d;
      out_eot_q     <= out_eot_d;
      out_total_q   <= out_total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kept_byte_o    = out_byte_q;
  assign byte_present_o = out_present_q;
  assign end_of_text_o  = out_eot_q;
  assign kept_total_o   = out_total_q;

  `QACS_ASSERT(a_fill_range, fill_q <= FILL_W'(MAX_DELIM), "window fill out of range")
  `QACS_ASSERT(a_fill_stream, flush_q || (fill_q != FILL_W'(MAX_DELIM)), "full window left undecided")
  `QACS_ASSERT(a_hold_flush, !hold_valid_q || flush_q, "held result outside a flush")
  `QACS_ASSERT_NEXT(a_drain_eot, step_drain, out_valid_o && end_of_text_o, "flush end lost")

endmodule
